// ----- rtl/imufd_pkg.sv -----
// Shared types, register map and reset constants for the IMU fall detector.
package imufd_pkg;

  // Field widths
  localparam int LEVEL_W  = 15;
  localparam int MS_W     = 16;
  localparam int TIME_W   = 32;
  localparam int AXIS_W   = 16;
  localparam int SQ_W     = 31;             // square of a 16-bit signed value
  localparam int LEVEL2_W = 2 * LEVEL_W;    // square of a 15-bit level
  localparam int MAG_W    = 32;             // sum of three squares

  // Register reset values
  localparam int FREEFALL_RST = 1638;
  localparam int IMPACT_RST   = 10240;
  localparam int ROTATION_RST = 3200;
  localparam int WINDOW_RST   = 1000;
  localparam int COOLDOWN_RST = 5000;
  localparam int HOLD_RST     = 5000;

  localparam logic [LEVEL2_W-1:0] FREEFALL2_RST = LEVEL2_W'(FREEFALL_RST * FREEFALL_RST);
  localparam logic [LEVEL2_W-1:0] IMPACT2_RST   = LEVEL2_W'(IMPACT_RST * IMPACT_RST);
  localparam logic [LEVEL2_W-1:0] ROTATION2_RST = LEVEL2_W'(ROTATION_RST * ROTATION_RST);

  // Register index map (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_FREEFALL = 3'd0,
    REG_IMPACT   = 3'd1,
    REG_ROTATION = 3'd2,
    REG_WINDOW   = 3'd3,
    REG_COOLDOWN = 3'd4,
    REG_HOLD     = 3'd5
  } imufd_reg_t;

  // Registered input sample
  typedef struct packed {
    logic              read_ok;
    logic [TIME_W-1:0] time_ms;
    logic [AXIS_W-1:0] accel_x;
    logic [AXIS_W-1:0] accel_y;
    logic [AXIS_W-1:0] accel_z;
    logic [AXIS_W-1:0] rate_x;
    logic [AXIS_W-1:0] rate_y;
    logic [AXIS_W-1:0] rate_z;
  } imufd_in_t;

  // Sample after the squaring stage
  typedef struct packed {
    logic              read_ok;
    logic [TIME_W-1:0] time_ms;
    logic [SQ_W-1:0]   ax2;
    logic [SQ_W-1:0]   ay2;
    logic [SQ_W-1:0]   az2;
    logic [SQ_W-1:0]   wx2;
    logic [SQ_W-1:0]   wy2;
    logic [SQ_W-1:0]   wz2;
  } imufd_sq_t;

  // Configuration as seen by the detector
  typedef struct packed {
    logic [LEVEL2_W-1:0] freefall2;
    logic [LEVEL2_W-1:0] impact2;
    logic [LEVEL2_W-1:0] rotation2;
    logic [MS_W-1:0]     window_ms;
    logic [MS_W-1:0]     cooldown_ms;
    logic [MS_W-1:0]     hold_ms;
  } imufd_cfg_t;

endpackage

// ----- rtl/imu_fall_detector.sv -----
// IMU fall detector: input register, squaring stage, fall logic and result register.
//
// Usage:
//   Slave stream (s_*) takes one sample per beat: s_tuser is read_ok, s_tdata
//   carries the millisecond timestamp and the six signed sensor axes. A beat
//   with read_ok low is a failed read: it yields a result with sensor_fault set
//   and leaves the detector state alone.
//   Master stream (m_*) returns exactly one result per sample, in order:
//   fall_event, fall_flag and armed in m_tdata, sensor_fault in m_tuser.
//   The APB port holds six thresholds at byte addresses 0x00..0x14; write them
//   only while no sample is in flight. pready is tied high.
// Timing:
//   Three register stages (input, squares, result). A sample passes the input,
//   squares and result registers in order; one sample per cycle is sustained while
//   m_tready stays high. Squared thresholds are registered after a register write.
// Reset: synchronous; clears all stages and the detector state and loads the
//   default thresholds.
// Stall: each stage holds while the one after it is full and stalled; a stage
//   with room keeps taking beats, so s_tready drops only when all three are full.
module imu_fall_detector
  import imufd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // time_ms[31:0], accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
  input  logic         s_tuser,   // read_ok
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [7:0]   m_tdata,   // fall_event, fall_flag, armed, zero fill [7:3]
  output logic         m_tuser,   // sensor_fault
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  imufd_in_t  in_beat;
  logic       in_valid;
  logic       mag_ready;
  imufd_sq_t  sq_beat;
  logic       sq_valid;
  logic       sq_ready;
  imufd_cfg_t cfg;

  assign s_tready = !in_valid || mag_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_beat.read_ok <= s_tuser;
      in_beat.time_ms <= s_tdata[31:0];
      in_beat.accel_x <= s_tdata[47:32];
      in_beat.accel_y <= s_tdata[63:48];
      in_beat.accel_z <= s_tdata[79:64];
      in_beat.rate_x  <= s_tdata[95:80];
      in_beat.rate_y  <= s_tdata[111:96];
      in_beat.rate_z  <= s_tdata[127:112];
    end
  end

  imufd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  imufd_mag u_mag (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_beat  (in_beat),
    .in_ready (mag_ready),
    .sq_valid (sq_valid),
    .sq_beat  (sq_beat),
    .sq_ready (sq_ready)
  );

  imufd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .sq_valid (sq_valid),
    .sq_beat  (sq_beat),
    .sq_ready (sq_ready),
    .cfg      (cfg),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

`ifndef ASSERT_OFF
  // A declared fall always leaves the detector disarmed
  a_event_disarms: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> !m_tdata[2])
    else $error("fall_event with armed still set");

  // A failed read never declares a fall
  a_fault_no_event: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> !m_tdata[0])
    else $error("fall_event on a failed read");

  // A squared sample blocked by the result register is kept
  a_sq_held: assert property (@(posedge clk) disable iff (rst)
    sq_valid && !sq_ready |=> sq_valid && $stable(sq_beat))
    else $error("squaring stage lost a stalled beat");
`endif

endmodule

// ----- rtl/imufd_cfg.sv -----
// APB register file for the fall detector thresholds, with squared levels.
module imufd_cfg
  import imufd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output imufd_cfg_t  cfg
);

  logic [LEVEL_W-1:0] freefall_level;
  logic [LEVEL_W-1:0] impact_level;
  logic [LEVEL_W-1:0] rotation_level;
  logic [MS_W-1:0]    impact_window_ms;
  logic [MS_W-1:0]    cooldown_ms;
  logic [MS_W-1:0]    flag_hold_ms;
  logic [LEVEL2_W-1:0] freefall2;
  logic [LEVEL2_W-1:0] impact2;
  logic [LEVEL2_W-1:0] rotation2;
  imufd_reg_t         idx;
  logic               wr;

  assign pready = 1'b1;
  assign idx    = imufd_reg_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite && pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      freefall_level   <= LEVEL_W'(FREEFALL_RST);
      impact_level     <= LEVEL_W'(IMPACT_RST);
      rotation_level   <= LEVEL_W'(ROTATION_RST);
      impact_window_ms <= MS_W'(WINDOW_RST);
      cooldown_ms      <= MS_W'(COOLDOWN_RST);
      flag_hold_ms     <= MS_W'(HOLD_RST);
    end else if (wr) begin
      unique case (idx)
        REG_FREEFALL: freefall_level   <= pwdata[LEVEL_W-1:0];
        REG_IMPACT:   impact_level     <= pwdata[LEVEL_W-1:0];
        REG_ROTATION: rotation_level   <= pwdata[LEVEL_W-1:0];
        REG_WINDOW:   impact_window_ms <= pwdata[MS_W-1:0];
        REG_COOLDOWN: cooldown_ms      <= pwdata[MS_W-1:0];
        REG_HOLD:     flag_hold_ms     <= pwdata[MS_W-1:0];
        default: ;
      endcase
    end
  end

  // Squared levels, one register behind the level registers
  always_ff @(posedge clk) begin
    if (rst) begin
      freefall2 <= FREEFALL2_RST;
      impact2   <= IMPACT2_RST;
      rotation2 <= ROTATION2_RST;
    end else begin
      freefall2 <= LEVEL2_W'(freefall_level) * LEVEL2_W'(freefall_level);
      impact2   <= LEVEL2_W'(impact_level) * LEVEL2_W'(impact_level);
      rotation2 <= LEVEL2_W'(rotation_level) * LEVEL2_W'(rotation_level);
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_FREEFALL: prdata = 32'(freefall_level);
      REG_IMPACT:   prdata = 32'(impact_level);
      REG_ROTATION: prdata = 32'(rotation_level);
      REG_WINDOW:   prdata = 32'(impact_window_ms);
      REG_COOLDOWN: prdata = 32'(cooldown_ms);
      REG_HOLD:     prdata = 32'(flag_hold_ms);
      default:      prdata = 32'd0;
    endcase
  end

  assign cfg.freefall2   = freefall2;
  assign cfg.impact2     = impact2;
  assign cfg.rotation2   = rotation2;
  assign cfg.window_ms   = impact_window_ms;
  assign cfg.cooldown_ms = cooldown_ms;
  assign cfg.hold_ms     = flag_hold_ms;

endmodule

// ----- rtl/imufd_mag.sv -----
// Squaring stage: per-axis squares of acceleration and angular rate.
module imufd_mag
  import imufd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  imufd_in_t in_beat,
  output logic      in_ready,
  output logic      sq_valid,
  output imufd_sq_t sq_beat,
  input  logic      sq_ready
);

  function automatic logic [SQ_W-1:0] sq16(input logic [AXIS_W-1:0] v);
    logic signed [2*AXIS_W-1:0] p;
    p = $signed(v) * $signed(v);
    return p[SQ_W-1:0];
  endfunction

  assign in_ready = !sq_valid || sq_ready;

  // Stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else if (in_ready) begin
      sq_valid <= in_valid;
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      sq_beat.read_ok <= in_beat.read_ok;
      sq_beat.time_ms <= in_beat.time_ms;
      sq_beat.ax2     <= sq16(in_beat.accel_x);
      sq_beat.ay2     <= sq16(in_beat.accel_y);
      sq_beat.az2     <= sq16(in_beat.accel_z);
      sq_beat.wx2     <= sq16(in_beat.rate_x);
      sq_beat.wy2     <= sq16(in_beat.rate_y);
      sq_beat.wz2     <= sq16(in_beat.rate_z);
    end
  end

endmodule

// ----- rtl/imufd_ctrl.sv -----
// Fall state machine and result register: free fall, impact window, flag hold.
module imufd_ctrl
  import imufd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       sq_valid,
  input  imufd_sq_t  sq_beat,
  output logic       sq_ready,
  input  imufd_cfg_t cfg,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [0] fall_event, [1] fall_flag, [2] armed, [7:3] zero
  output logic       m_tuser    // [0] sensor_fault
);

  logic              freefall_phase;
  logic [TIME_W-1:0] freefall_start;
  logic [TIME_W-1:0] last_fall_time;
  logic [TIME_W-1:0] flag_set_time;
  logic              flag_raised;

  logic              freefall_phase_next;
  logic [TIME_W-1:0] freefall_start_next;
  logic [TIME_W-1:0] last_fall_time_next;
  logic [TIME_W-1:0] flag_set_time_next;
  logic              flag_raised_next;
  logic              event_next;

  logic [MAG_W-1:0]  acc;
  logic [MAG_W-1:0]  rot;
  logic [TIME_W-1:0] now;
  logic [TIME_W-1:0] el_cool;
  logic [TIME_W-1:0] el_win;
  logic [TIME_W-1:0] el_hold;
  logic              advance;

  assign sq_ready = !m_tvalid || m_tready;
  assign advance  = sq_valid && sq_ready;

  // Magnitudes and elapsed times (all differences wrap at 32 bits)
  assign acc     = MAG_W'(sq_beat.ax2) + MAG_W'(sq_beat.ay2) + MAG_W'(sq_beat.az2);
  assign rot     = MAG_W'(sq_beat.wx2) + MAG_W'(sq_beat.wy2) + MAG_W'(sq_beat.wz2);
  assign now     = sq_beat.time_ms;
  assign el_cool = now - last_fall_time;
  assign el_win  = now - freefall_start;

  // Next state for a valid sample; a failed read leaves everything as is
  always_comb begin
    freefall_phase_next = freefall_phase;
    freefall_start_next = freefall_start;
    last_fall_time_next = last_fall_time;
    flag_set_time_next  = flag_set_time;
    flag_raised_next    = flag_raised;
    event_next          = 1'b0;
    el_hold             = now - flag_set_time;
    if (sq_beat.read_ok) begin
      if (!freefall_phase) begin
        if (acc < MAG_W'(cfg.freefall2) && el_cool > TIME_W'(cfg.cooldown_ms)) begin
          freefall_phase_next = 1'b1;
          freefall_start_next = now;
        end
      end else if (el_win <= TIME_W'(cfg.window_ms)) begin
        if (acc > MAG_W'(cfg.impact2) && rot > MAG_W'(cfg.rotation2)) begin
          event_next          = 1'b1;
          flag_raised_next    = 1'b1;
          last_fall_time_next = now;
          flag_set_time_next  = now;
          freefall_phase_next = 1'b0;
        end
      end else begin
        freefall_phase_next = 1'b0;
      end
      // a flag set on this sample has zero elapsed time
      if (event_next) begin
        el_hold = '0;
      end
      if (flag_raised_next && el_hold >= TIME_W'(cfg.hold_ms)) begin
        flag_raised_next   = 1'b0;
        flag_set_time_next = '0;
      end
    end
  end

  // Detector state
  always_ff @(posedge clk) begin
    if (rst) begin
      freefall_phase <= 1'b0;
      freefall_start <= '0;
      last_fall_time <= '0;
      flag_set_time  <= '0;
      flag_raised    <= 1'b0;
    end else if (advance) begin
      freefall_phase <= freefall_phase_next;
      freefall_start <= freefall_start_next;
      last_fall_time <= last_fall_time_next;
      flag_set_time  <= flag_set_time_next;
      flag_raised    <= flag_raised_next;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (sq_ready) begin
      m_tvalid <= sq_valid;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {5'b0, freefall_phase_next, flag_raised_next, event_next};
      m_tuser <= !sq_beat.read_ok;
    end
  end

endmodule
